>>> rtl/rsat_pkg.sv
`default_nettype none

package rsat_pkg;

  localparam int SIZE       = 1024;
  localparam int LEAF_DEPTH = $clog2(SIZE);
  localparam int IDX_W      = 10;
  localparam int NODE_W     = LEAF_DEPTH + 1;
  localparam int NODES      = 2 * SIZE;
  localparam int DEPTH_W    = $clog2(LEAF_DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int EXT_W      = VAL_W + 1;
  localparam int SUM_W      = 42;
  localparam int CFG_W      = 11;

  localparam logic [1:0] FUNC_ASSIGN = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_FIRST  = 2'd2;
  localparam logic [1:0] FUNC_LAST   = 2'd3;

  // empty marks sit just outside the value range
  localparam logic signed [EXT_W-1:0] EMPTY_MIN = EXT_W'(1) << (VAL_W - 1);
  localparam logic signed [EXT_W-1:0] EMPTY_MAX = ~EMPTY_MIN;
  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        range_left;
    logic [IDX_W-1:0]        range_right;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic signed [VAL_W-1:0] range_min;
    logic signed [VAL_W-1:0] range_max;
    logic                    range_empty;
    logic [IDX_W-1:0]        found_index;
    logic                    found;
  } result_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_v;
    logic signed [EXT_W-1:0] min_v;
    logic signed [EXT_W-1:0] max_v;
  } span_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_v;
    logic signed [EXT_W-1:0] min_v;
    logic signed [EXT_W-1:0] max_v;
    logic signed [VAL_W-1:0] pend_v;
    logic                    pend;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  localparam node_t RESET_NODE = '{sum_v: '0, min_v: EMPTY_MIN, max_v: EMPTY_MAX,
                                   pend_v: '0, pend: 1'b0};

  typedef struct packed {
    logic start;
    logic rd;
    logic clr_wr;
    logic w_span;
    logic push_a;
    logic push_b;
    logic push_n;
    logic desc;
    logic sib;
    logic up;
    logic ret_self;
    logic ret_span;
    logic acc;
    logic set_found;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       empty;
    logic [1:0] op;
    logic       disjoint;
    logic       covered;
    logic       leaf;
    logic       pending;
    logic       min_ge;
    logic       root;
    logic       phase_top;
    logic       out_free;
  } stat_t;

  function automatic logic [IDX_W-1:0] node_lo(logic [NODE_W-1:0] n,
                                               logic [DEPTH_W-1:0] d);
    logic [NODE_W-1:0] pos;
    pos = n & ~(NODE_W'(1) << d);
    return IDX_W'(pos << (DEPTH_W'(LEAF_DEPTH) - d));
  endfunction

  function automatic logic [IDX_W-1:0] node_hi(logic [NODE_W-1:0] n,
                                               logic [DEPTH_W-1:0] d);
    logic [NODE_W-1:0] span_m1;
    span_m1 = (NODE_W'(1) << (DEPTH_W'(LEAF_DEPTH) - d)) - NODE_W'(1);
    return node_lo(n, d) | IDX_W'(span_m1);
  endfunction

  // every element of a span of 2**sh set to v
  function automatic node_t span_word(logic signed [VAL_W-1:0] v,
                                      logic [DEPTH_W-1:0] sh);
    node_t w;
    w.sum_v  = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v} << sh;
    w.min_v  = {v[VAL_W-1], v};
    w.max_v  = {v[VAL_W-1], v};
    w.pend_v = v;
    w.pend   = 1'b1;
    return w;
  endfunction

  function automatic span_t to_span(node_t w);
    span_t s;
    s.sum_v = w.sum_v;
    s.min_v = w.min_v;
    s.max_v = w.max_v;
    return s;
  endfunction

  function automatic span_t combine(span_t a, span_t b);
    span_t s;
    s.sum_v = a.sum_v + b.sum_v;
    s.min_v = (a.min_v < b.min_v) ? a.min_v : b.min_v;
    s.max_v = (a.max_v > b.max_v) ? a.max_v : b.max_v;
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rsat_ram.sv
`default_nettype none

module rsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsat_dp.sv
`default_nettype none

module rsat_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rsat_pkg::item_t               item,
  input  wire logic                          cfg_write_en,
  input  wire logic [rsat_pkg::CFG_W-1:0]    cfg_write_data,
  output      logic                          result_valid,
  input  wire logic                          result_ready,
  output      rsat_pkg::result_t             result,
  input  wire rsat_pkg::cmd_t                cmd,
  output      rsat_pkg::stat_t               st
);

  localparam int NW = rsat_pkg::NODE_W;
  localparam int DW = rsat_pkg::DEPTH_W;
  localparam int IW = rsat_pkg::IDX_W;

  logic [1:0]                      op;
  logic [IW-1:0]                   left;
  logic [IW-1:0]                   right;
  logic signed [rsat_pkg::VAL_W-1:0] val;
  logic                            empty;
  logic [IW-1:0]                   size_top;
  logic [NW-1:0]                   node;
  logic [DW-1:0]                   depth;
  logic [rsat_pkg::LEAF_DEPTH-1:0] phase;
  rsat_pkg::span_t                 lres [rsat_pkg::LEAF_DEPTH];
  rsat_pkg::span_t                 ret;
  rsat_pkg::span_t                 acc;
  logic                            found;
  logic [IW-1:0]                   found_idx;
  logic [NW-1:0]                   clr_cnt;

  logic [DW-1:0]          depth_m1;
  logic [DW-1:0]          sh_node;
  logic [DW-1:0]          sh_child;
  logic [IW-1:0]          lo;
  logic [IW-1:0]          hi;
  logic [IW-1:0]          right_clip;
  logic [rsat_pkg::CFG_W-1:0] cfg_size;
  rsat_pkg::node_t        rd_w;
  rsat_pkg::node_t        wr_w;
  rsat_pkg::span_t        cmb;
  rsat_pkg::result_t      res_next;
  logic                   ram_we;
  logic [NW-1:0]          ram_waddr;
  logic [rsat_pkg::NODE_BITS-1:0] ram_rdata;

  rsat_ram #(
    .WIDTH (rsat_pkg::NODE_BITS),
    .DEPTH (rsat_pkg::NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_w),
    .re    (cmd.rd),
    .raddr (node),
    .rdata (ram_rdata)
  );

  assign rd_w     = rsat_pkg::node_t'(ram_rdata);
  assign depth_m1 = depth - DW'(1);
  assign sh_node  = DW'(rsat_pkg::LEAF_DEPTH) - depth;
  assign sh_child = sh_node - DW'(1);
  assign lo       = rsat_pkg::node_lo(node, depth);
  assign hi       = rsat_pkg::node_hi(node, depth);
  assign cmb      = rsat_pkg::combine(lres[depth_m1], ret);

  assign right_clip = (item.range_right > size_top) ? size_top : item.range_right;

  always_comb begin
    if (cfg_write_data == '0) begin
      cfg_size = rsat_pkg::CFG_W'(1);
    end else if (cfg_write_data > rsat_pkg::CFG_W'(rsat_pkg::SIZE)) begin
      cfg_size = rsat_pkg::CFG_W'(rsat_pkg::SIZE);
    end else begin
      cfg_size = cfg_write_data;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    wr_w      = rsat_pkg::RESET_NODE;
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
    end else if (cmd.w_span) begin
      ram_we = 1'b1;
      wr_w   = rsat_pkg::span_word(val, sh_node);
    end else if (cmd.push_a) begin
      ram_we    = 1'b1;
      ram_waddr = {node[NW-2:0], 1'b0};
      wr_w      = rsat_pkg::span_word(rd_w.pend_v, sh_child);
    end else if (cmd.push_b) begin
      ram_we    = 1'b1;
      ram_waddr = {node[NW-2:0], 1'b1};
      wr_w      = rsat_pkg::span_word(rd_w.pend_v, sh_child);
    end else if (cmd.push_n) begin
      ram_we    = 1'b1;
      wr_w      = rd_w;
      wr_w.pend = 1'b0;
    end else if (cmd.up && op == rsat_pkg::FUNC_ASSIGN) begin
      ram_we       = 1'b1;
      ram_waddr    = {1'b0, node[NW-1:1]};
      wr_w.sum_v   = cmb.sum_v;
      wr_w.min_v   = cmb.min_v;
      wr_w.max_v   = cmb.max_v;
      wr_w.pend_v  = '0;
      wr_w.pend    = 1'b0;
    end
  end

  always_comb begin
    res_next = '0;
    case (op)
      rsat_pkg::FUNC_QUERY: begin
        res_next.range_sum   = acc.sum_v;
        res_next.range_min   = (acc.min_v == rsat_pkg::EMPTY_MIN) ? rsat_pkg::VMAX
                                                                  : acc.min_v[rsat_pkg::VAL_W-1:0];
        res_next.range_max   = (acc.max_v == rsat_pkg::EMPTY_MAX) ? rsat_pkg::VMIN
                                                                  : acc.max_v[rsat_pkg::VAL_W-1:0];
        res_next.range_empty = empty;
      end
      rsat_pkg::FUNC_FIRST, rsat_pkg::FUNC_LAST: begin
        res_next.found_index = found ? found_idx : '0;
        res_next.found       = found;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_comb begin
    st.clr_last  = (clr_cnt == NW'(rsat_pkg::NODES - 1));
    st.empty     = empty;
    st.op        = op;
    st.disjoint  = (lo > right) || (hi < left);
    st.covered   = (left <= lo) && (hi <= right);
    st.leaf      = (depth == DW'(rsat_pkg::LEAF_DEPTH));
    st.pending   = rd_w.pend;
    st.min_ge    = (rd_w.min_v >= $signed({val[rsat_pkg::VAL_W-1], val}));
    st.root      = (depth == '0);
    st.phase_top = (depth == '0) ? 1'b0 : phase[depth_m1];
    st.out_free  = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      clr_cnt      <= '0;
      size_top     <= IW'(rsat_pkg::SIZE - 1);
    end else begin
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        size_top <= IW'(cfg_size - rsat_pkg::CFG_W'(1));
        clr_cnt  <= '0;
      end else if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op        <= item.func;
      left      <= item.range_left;
      right     <= right_clip;
      val       <= item.value;
      empty     <= item.range_left > right_clip;
      node      <= NW'(1);
      depth     <= '0;
      acc       <= '{sum_v: '0, min_v: rsat_pkg::EMPTY_MIN, max_v: rsat_pkg::EMPTY_MAX};
      found     <= 1'b0;
      found_idx <= '0;
    end
    if (cmd.desc) begin
      phase[depth] <= 1'b0;
      node         <= {node[NW-2:0], op == rsat_pkg::FUNC_LAST};
      depth        <= depth + DW'(1);
    end
    if (cmd.sib) begin
      phase[depth_m1] <= 1'b1;
      node            <= node ^ NW'(1);
      if (op == rsat_pkg::FUNC_ASSIGN) begin
        lres[depth_m1] <= ret;
      end
    end
    if (cmd.up) begin
      node  <= {1'b0, node[NW-1:1]};
      depth <= depth_m1;
      if (op == rsat_pkg::FUNC_ASSIGN) begin
        ret <= cmb;
      end
    end
    if (cmd.ret_self) begin
      ret <= rsat_pkg::to_span(rd_w);
    end
    if (cmd.ret_span) begin
      ret <= rsat_pkg::to_span(rsat_pkg::span_word(val, sh_node));
    end
    if (cmd.acc) begin
      acc <= rsat_pkg::combine(acc, rsat_pkg::to_span(rd_w));
    end
    if (cmd.set_found) begin
      found     <= 1'b1;
      found_idx <= lo;
    end
    if (cmd.load_out) begin
      result <= res_next;
    end
  end

  a_desc_internal: assert property (@(posedge clk) disable iff (rst)
    cmd.desc |-> depth < DW'(rsat_pkg::LEAF_DEPTH))
    else $error("descend from a leaf");

  a_read_node: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> node != '0)
    else $error("read of unused node slot");

  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    cmd.up |-> depth != '0)
    else $error("ascend above root");

endmodule

`default_nettype wire

>>> rtl/rsat_ctrl.sv
`default_nettype none

module rsat_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output      logic            item_ready,
  input  wire logic            cfg_write_en,
  input  wire rsat_pkg::stat_t st,
  output      rsat_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_READ   = 10'b0000000100,
    S_EVAL   = 10'b0000001000,
    S_PUSH_A = 10'b0000010000,
    S_PUSH_B = 10'b0000100000,
    S_PUSH_N = 10'b0001000000,
    S_DESC   = 10'b0010000000,
    S_RET    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (st.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (st.op)
          rsat_pkg::FUNC_ASSIGN: begin
            if (st.disjoint) begin
              cmd.ret_self = 1'b1;
              state_next   = S_RET;
            end else if (st.covered) begin
              cmd.w_span   = 1'b1;
              cmd.ret_span = 1'b1;
              state_next   = S_RET;
            end else begin
              state_next = st.pending ? S_PUSH_A : S_DESC;
            end
          end
          rsat_pkg::FUNC_QUERY: begin
            if (st.disjoint) begin
              state_next = S_RET;
            end else if (st.covered) begin
              cmd.acc    = 1'b1;
              state_next = S_RET;
            end else begin
              state_next = st.pending ? S_PUSH_A : S_DESC;
            end
          end
          default: begin
            if (st.disjoint || st.min_ge) begin
              state_next = S_RET;
            end else if (st.leaf) begin
              cmd.set_found = 1'b1;
              state_next    = S_DONE;
            end else begin
              state_next = st.pending ? S_PUSH_A : S_DESC;
            end
          end
        endcase
      end
      S_PUSH_A: begin
        cmd.push_a = 1'b1;
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd.push_b = 1'b1;
        state_next = (st.op == rsat_pkg::FUNC_ASSIGN) ? S_DESC : S_PUSH_N;
      end
      S_PUSH_N: begin
        cmd.push_n = 1'b1;
        state_next = S_DESC;
      end
      S_DESC: begin
        cmd.desc   = 1'b1;
        state_next = S_READ;
      end
      S_RET: begin
        if (st.root) begin
          state_next = S_DONE;
        end else if (!st.phase_top) begin
          cmd.sib    = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.up = 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_write_en) begin
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state != S_IDLE)
    else $error("beat accepted but controller still idle");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> state == S_CLEAR)
    else $error("size write did not start clearing");

endmodule

`default_nettype wire

>>> rtl/range_assign_segment_tree.sv
// Range-assign segment tree over 1024 signed 32-bit elements.
// item channel (valid/ready): func, range_left, range_right, value.
//   func 0 assigns value over the range, 1 returns sum/min/max of the range,
//   2 and 3 return the lowest/highest index in the range below value.
// result channel (valid/ready): one beat per item, assigns included.
// cfg_write_en/cfg_write_data set the number of elements in use; a write
//   clears the whole tree. Right bounds beyond it are clipped.
// Nodes live in one 2048-word memory with one write and one registered read
//   port; each node visit costs a read plus evaluation, a return step per
//   level on the way back, and up to three writes when a pending assignment
//   is pushed to the children.
//   An empty range skips the tree walk and goes straight to the result.
//   Items are processed one at a time.
// Reset, and every cfg write, runs a clearing sweep over all 2048 node words
//   with item_ready low.
// A finished result waits in the output register; the next item is accepted
//   meanwhile and only its completion stalls until that beat is taken.
`default_nettype none

module range_assign_segment_tree (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output      logic                       item_ready,
  input  wire rsat_pkg::item_t            item,
  output      logic                       result_valid,
  input  wire logic                       result_ready,
  output      rsat_pkg::result_t          result,
  input  wire logic                       cfg_write_en,
  input  wire logic [rsat_pkg::CFG_W-1:0] cfg_write_data
);

  rsat_pkg::cmd_t  cmd;
  rsat_pkg::stat_t st;

  rsat_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cfg_write_en (cfg_write_en),
    .st           (st),
    .cmd          (cmd)
  );

  rsat_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
  import rsat_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AT     = 200;
  localparam int SETTLE      = 400;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_ready;
  item_t                item;
  logic                 result_valid;
  logic                 result_ready;
  result_t              result;
  logic                 cfg_write_en;
  logic [CFG_W-1:0]     cfg_write_data;

  range_assign_segment_tree i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // element-level view of the array
  int        elem_val [SIZE];
  bit        elem_set [SIZE];
  int        size_in_use;
  result_t   expected_results [$];
  row_t      directed_rows [$];
  int        mismatches;
  int        beats_in;
  bit        hold;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void clear_array(int sz);
    for (int k = 0; k < SIZE; k++) begin
      elem_set[k] = 1'b0;
      elem_val[k] = 0;
    end
    size_in_use = sz;
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t res;
    int      lo;
    int      hi;
    longint  sum;
    longint  mn;
    longint  mx;
    res = '0;
    lo = it.range_left;
    hi = it.range_right;
    if (hi > size_in_use - 1) hi = size_in_use - 1;
    case (it.func)
      FUNC_ASSIGN: begin
        for (int k = lo; k <= hi; k++) begin
          elem_set[k] = 1'b1;
          elem_val[k] = it.value;
        end
      end
      FUNC_QUERY: begin
        sum = 0;
        mn = longint'(VMAX);
        mx = longint'(VMIN);
        for (int k = lo; k <= hi; k++) begin
          if (elem_set[k]) begin
            sum += elem_val[k];
            if (elem_val[k] < mn) mn = elem_val[k];
            if (elem_val[k] > mx) mx = elem_val[k];
          end
        end
        res.range_sum   = sum[SUM_W-1:0];
        res.range_min   = mn[VAL_W-1:0];
        res.range_max   = mx[VAL_W-1:0];
        res.range_empty = (lo > hi);
      end
      FUNC_FIRST: begin
        for (int k = lo; k <= hi; k++) begin
          if (elem_set[k] && elem_val[k] < it.value) begin
            res.found_index = k[IDX_W-1:0];
            res.found = 1'b1;
            break;
          end
        end
      end
      default: begin
        for (int k = hi; k >= lo; k--) begin
          if (elem_set[k] && elem_val[k] < it.value) begin
            res.found_index = k[IDX_W-1:0];
            res.found = 1'b1;
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    int    top;
    top = size_in_use - 1;
    pick = $urandom_range(0, 99);
    it.func = (pick < 35) ? FUNC_ASSIGN : (pick < 65) ? FUNC_QUERY :
              (pick < 83) ? FUNC_FIRST : FUNC_LAST;
    if ($urandom_range(0, 99) < 15) begin
      it.range_left  = $urandom;
      it.range_right = $urandom;
    end else begin
      it.range_left  = $urandom_range(0, top);
      if ($urandom_range(0, 1))
        it.range_right = $urandom_range(it.range_left, top);
      else
        it.range_right = $urandom_range(it.range_left,
                           (it.range_left + 8 > top) ? top : it.range_left + 8);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.value = $signed($urandom_range(0, 40)) - 20;
    else if (pick < 52) it.value = VMAX;
    else if (pick < 59) it.value = VMIN;
    else                it.value = $urandom;
    return it;
  endfunction

  task automatic add_row(logic [1:0] f, int l, int r, logic signed [VAL_W-1:0] v,
                         bit typed, result_t want);
    row_t rw;
    rw.it.func        = f;
    rw.it.range_left  = l;
    rw.it.range_right = r;
    rw.it.value       = v;
    rw.typed          = typed;
    rw.want           = want;
    directed_rows.push_back(rw);
  endtask

  task automatic send_item(item_t it, bit typed, result_t want, bit quiet);
    result_t pred;
    int      gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    pred = apply_item(it);
    expected_results.push_back(typed ? want : pred);
    beats_in++;
  endtask

  task automatic drain_and_settle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(int v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    if (v < 1) v = 1;
    if (v > SIZE) v = SIZE;
    clear_array(v);
  endtask

  // receiver
  initial begin
    int gap;
    bit quiet;
    result_ready = 1'b0;
    quiet = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0 || hold) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  // long back-pressure stretch
  initial begin
    hold = 1'b0;
    wait (beats_in >= HOLD_AT);
    @(posedge clk);
    hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold = 1'b0;
  end

  always @(posedge clk) begin
    result_t want;
    bit      bad;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", result);
      end else begin
        want = expected_results.pop_front();
        bad = (result.range_sum !== want.range_sum) ||
              (result.range_min !== want.range_min) ||
              (result.range_max !== want.range_max) ||
              (result.range_empty !== want.range_empty) ||
              (result.found_index !== want.found_index) ||
              (result.found !== want.found);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp %p got %p", want, result);
        end
      end
    end
  end

  initial begin
    int      sizes [6];
    result_t none;
    result_t blank;
    result_t nothing_in;
    bit      quiet;
    sizes      = '{0, 37, 2047, 1000, 5, 1024};
    none       = '0;
    blank      = '{42'sd0, VMAX, VMIN, 1'b0, 10'd0, 1'b0};
    nothing_in = '{42'sd0, VMAX, VMIN, 1'b1, 10'd0, 1'b0};
    cycles = 0;
    mismatches = 0;
    beats_in = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    clear_array(SIZE);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_row(FUNC_QUERY,  0, 1023, 0, 1, blank);
    add_row(FUNC_FIRST,  0, 1023, VMAX, 1, none);
    add_row(FUNC_LAST,   0, 1023, VMAX, 1, none);
    add_row(FUNC_QUERY,  5, 3, 0, 1, nothing_in);
    add_row(FUNC_ASSIGN, 9, 2, 77, 1, none);
    add_row(FUNC_QUERY,  0, 1023, 0, 1, blank);
    add_row(FUNC_ASSIGN, 0, 1023, 0, 1, none);
    add_row(FUNC_QUERY,  0, 1023, 0, 1, '0);
    add_row(FUNC_ASSIGN, 1023, 1023, VMIN, 1, none);
    add_row(FUNC_FIRST,  0, 1023, 0, 0, none);
    add_row(FUNC_LAST,   0, 1023, VMIN, 1, none);
    add_row(FUNC_ASSIGN, 0, 0, VMAX, 1, none);
    add_row(FUNC_QUERY,  0, 1023, 0, 0, none);
    add_row(FUNC_ASSIGN, 512, 700, -5, 1, none);
    add_row(FUNC_QUERY,  500, 600, 0, 0, none);
    add_row(FUNC_FIRST,  0, 1023, -4, 0, none);
    add_row(FUNC_LAST,   0, 1022, -4, 0, none);
    add_row(FUNC_FIRST,  701, 1022, 1, 0, none);
    add_row(FUNC_ASSIGN, 0, 1023, VMAX, 1, none);
    add_row(FUNC_QUERY,  0, 1023, 0, 0, none);
    add_row(FUNC_ASSIGN, 300, 300, VMIN, 1, none);
    add_row(FUNC_QUERY,  0, 1023, 0, 0, none);
    add_row(FUNC_LAST,   0, 1023, VMAX, 0, none);

    foreach (directed_rows[k])
      send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want,
                k < 8);

    foreach (sizes[p]) begin
      drain_and_settle();
      write_size(sizes[p]);
      quiet = 1'b0;
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
        send_item(random_item(), 1'b0, none, quiet);
      end
    end
    drain_and_settle();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rsat_pkg.sv
rtl/rsat_ram.sv
rtl/rsat_dp.sv
rtl/rsat_ctrl.sv
rtl/range_assign_segment_tree.sv
verif/tb_top.sv
